// ===== hdl/nfawa_pkg.sv =====
// Shared types and constants for the NFA word acceptor.
// No dependencies; imported by the rule table and the top level.
package nfawa_pkg;

  localparam int unsigned DefMaxRules  = 32;
  localparam int unsigned DefNumStates = 16;

  localparam int unsigned KindW  = 2;
  localparam int unsigned IndexW = 5;
  localparam int unsigned StateW = 4;
  localparam int unsigned SymW   = 8;

  // A rule with this symbol marks its source state as final.
  localparam logic [SymW-1:0] FinalMark = 8'd35;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef struct packed {
    logic              en;
    logic [IndexW-1:0] index;
    logic [StateW-1:0] from;
    logic [SymW-1:0]   symbol;
    logic [StateW-1:0] to;
  } rule_wr_t;

endpackage

// ===== hdl/nfawa_rule_table.sv =====
// Rule table with one compare cell per slot, and the parallel subset step.
// Depends on nfawa_pkg.
module nfawa_rule_table import nfawa_pkg::*; #(
  parameter int unsigned MAX_RULES  = DefMaxRules,
  parameter int unsigned NUM_STATES = DefNumStates
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rule_wr_t              wr_i,
  input  logic [NUM_STATES-1:0] cur_set_i,
  input  logic [SymW-1:0]       word_byte_i,
  output logic [NUM_STATES-1:0] next_set_o,
  output logic                  final_hit_o
);

  logic              valid_q  [MAX_RULES];
  logic [StateW-1:0] from_q   [MAX_RULES];
  logic [SymW-1:0]   symbol_q [MAX_RULES];
  logic [StateW-1:0] to_q     [MAX_RULES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < int'(MAX_RULES); r++) begin
        valid_q[r] <= 1'b0;
      end
    end else if (wr_i.en) begin
      for (int r = 0; r < int'(MAX_RULES); r++) begin
        if (int'(wr_i.index) == r) begin
          valid_q[r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      for (int r = 0; r < int'(MAX_RULES); r++) begin
        if (int'(wr_i.index) == r) begin
          from_q[r]   <= wr_i.from;
          symbol_q[r] <= wr_i.symbol;
          to_q[r]     <= wr_i.to;
        end
      end
    end
  end

  // Each cell checks that its source state is active; states at or above
  // NUM_STATES never match, and destinations there add nothing.
  always_comb begin
    logic src_active;
    next_set_o  = '0;
    final_hit_o = 1'b0;
    for (int r = 0; r < int'(MAX_RULES); r++) begin
      src_active = 1'b0;
      for (int s = 0; s < int'(NUM_STATES); s++) begin
        if (int'(from_q[r]) == s && cur_set_i[s]) begin
          src_active = 1'b1;
        end
      end
      if (valid_q[r] && src_active) begin
        if (symbol_q[r] == word_byte_i) begin
          for (int s = 0; s < int'(NUM_STATES); s++) begin
            if (int'(to_q[r]) == s) begin
              next_set_o[s] = 1'b1;
            end
          end
        end
        if (symbol_q[r] == FinalMark) begin
          final_hit_o = 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/nfa_word_acceptor_unit.sv =====
// Top level of the NFA word acceptor: input register, active-set state,
// result register. Depends on nfawa_pkg and nfawa_rule_table.
//
// Usage: items arrive on the input channel (in_valid_i / in_stall_o) with
// kind_i selecting a rule load, a word symbol or an end of word. Only an
// end-of-word item gives a result, on the output channel (out_valid_o /
// out_stall_i) as accepted_o. The start state is written through
// cfg_we_i / cfg_wdata_i while the block is idle.
// An item is captured in the input register and processed from there, where
// all rule cells compare in parallel against the active set; an end-of-word
// item loads the result register as it leaves the input register.
// Throughput: one item per cycle, unless an end-of-word item waits on a full,
// stalled result register; the rule compare is combinational.
// When the receiver stalls, the result register holds its item; the input
// register keeps flowing for loads and symbols and stops only when an
// end-of-word item meets a full, stalled result register.
// Reset clears all rule valid bits, the active set, the open-word flag,
// the start state and both valid flags.
module nfa_word_acceptor_unit import nfawa_pkg::*; #(
  parameter int unsigned MAX_RULES  = DefMaxRules,
  parameter int unsigned NUM_STATES = DefNumStates
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [StateW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [KindW-1:0]  kind_i,
  input  logic [IndexW-1:0] rule_index_i,
  input  logic [StateW-1:0] rule_from_i,
  input  logic [SymW-1:0]   rule_symbol_i,
  input  logic [StateW-1:0] rule_to_i,
  input  logic [SymW-1:0]   word_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              accepted_o
);

  logic [StateW-1:0]     start_state_q;
  logic                  in_valid_q;
  logic [KindW-1:0]      kind_q;
  logic [IndexW-1:0]     rule_index_q;
  logic [StateW-1:0]     rule_from_q;
  logic [SymW-1:0]       rule_symbol_q;
  logic [StateW-1:0]     rule_to_q;
  logic [SymW-1:0]       word_byte_q;
  logic [NUM_STATES-1:0] active_q;
  logic                  word_open_q;
  logic                  out_valid_q;
  logic                  accepted_q;

  logic                  advance;
  logic                  in_accept;
  logic                  is_end;
  logic [NUM_STATES-1:0] start_set;
  logic [NUM_STATES-1:0] cur_set;
  logic [NUM_STATES-1:0] next_set;
  logic                  final_hit;
  rule_wr_t              rule_wr;

  assign is_end    = (kind_e'(kind_q) == KIND_END);
  assign advance   = in_valid_q && (!is_end || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    start_set = '0;
    for (int s = 0; s < int'(NUM_STATES); s++) begin
      if (int'(start_state_q) == s) begin
        start_set[s] = 1'b1;
      end
    end
  end

  // A word that has not begun yet starts from the start state.
  assign cur_set = word_open_q ? active_q : start_set;

  always_comb begin
    rule_wr.en     = advance && (kind_e'(kind_q) == KIND_LOAD) &&
                     (int'(rule_index_q) < int'(MAX_RULES));
    rule_wr.index  = rule_index_q;
    rule_wr.from   = rule_from_q;
    rule_wr.symbol = rule_symbol_q;
    rule_wr.to     = rule_to_q;
  end

  nfawa_rule_table #(
    .MAX_RULES  (MAX_RULES),
    .NUM_STATES (NUM_STATES)
  ) u_rule_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (rule_wr),
    .cur_set_i   (cur_set),
    .word_byte_i (word_byte_q),
    .next_set_o  (next_set),
    .final_hit_o (final_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= '0;
    end else if (cfg_we_i) begin
      start_state_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q        <= kind_i;
      rule_index_q  <= rule_index_i;
      rule_from_q   <= rule_from_i;
      rule_symbol_q <= rule_symbol_i;
      rule_to_q     <= rule_to_i;
      word_byte_q   <= word_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      word_open_q <= 1'b0;
    end else if (advance) begin
      case (kind_e'(kind_q))
        KIND_SYMBOL: begin
          active_q    <= next_set;
          word_open_q <= 1'b1;
        end
        KIND_END: begin
          active_q    <= '0;
          word_open_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_end) begin
      accepted_q <= final_hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for nfa_word_acceptor_unit: loads transition rules,
// runs words through the automaton and checks every acceptance verdict.
// Depends on nfawa_pkg and the RTL of the unit only.
module testbench;
  import nfawa_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int MaxRules    = DefMaxRules;
  localparam int NumStates   = DefNumStates;
  localparam int ItemTarget  = 900;
  localparam int DrainCycles = 6;
  localparam int FinalWait   = 4000;
  localparam int LongHold    = 250;
  localparam int LimitTime   = 5_000_000;

  // Kind code that the block has to ignore.
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam logic [SymW-1:0]  SymA       = 8'd97;

  typedef struct {
    logic [KindW-1:0]  kind;
    logic [IndexW-1:0] index;
    logic [StateW-1:0] from;
    logic [SymW-1:0]   symbol;
    logic [StateW-1:0] to;
    logic [SymW-1:0]   word_byte;
  } nfa_item_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [StateW-1:0] cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [KindW-1:0]  kind_i        = '0;
  logic [IndexW-1:0] rule_index_i  = '0;
  logic [StateW-1:0] rule_from_i   = '0;
  logic [SymW-1:0]   rule_symbol_i = '0;
  logic [StateW-1:0] rule_to_i     = '0;
  logic [SymW-1:0]   word_byte_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic              accepted_o;

  // Predictor state.
  logic [StateW-1:0]    start_q;
  logic [NumStates-1:0] active_q;
  logic                 word_open_q;
  logic                 rule_ok  [MaxRules];
  logic [StateW-1:0]    rule_src [MaxRules];
  logic [SymW-1:0]      rule_sym [MaxRules];
  logic [StateW-1:0]    rule_dst [MaxRules];

  logic expected_verdicts [$];

  int unsigned tx_gap_max     = 19;
  int unsigned rx_stall_max   = 19;
  int unsigned rx_hold_cycles = 0;
  int unsigned items_sent     = 0;
  int unsigned words_ended    = 0;
  int unsigned verdicts_seen  = 0;
  int unsigned words_accepted = 0;
  int unsigned start_writes   = 0;
  int unsigned long_holds     = 0;
  int unsigned fail_count     = 0;

  nfa_word_acceptor_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .rule_index_i (rule_index_i),
    .rule_from_i  (rule_from_i),
    .rule_symbol_i(rule_symbol_i),
    .rule_to_i    (rule_to_i),
    .word_byte_i  (word_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .accepted_o   (accepted_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [NumStates-1:0] state_mask(input logic [StateW-1:0] s);
    if (s >= NumStates) return '0;
    return NumStates'(1) << s;
  endfunction

  // Advances the automaton by one accepted item and queues any verdict.
  function automatic void predict_nfa_step(input nfa_item_t it);
    logic [NumStates-1:0] cur;
    logic [NumStates-1:0] nxt;
    logic                 hit;
    cur = word_open_q ? active_q : state_mask(start_q);
    nxt = '0;
    hit = 1'b0;
    case (it.kind)
      KIND_LOAD: begin
        if (it.index < MaxRules) begin
          rule_ok[it.index]  = 1'b1;
          rule_src[it.index] = it.from;
          rule_sym[it.index] = it.symbol;
          rule_dst[it.index] = it.to;
        end
      end
      KIND_SYMBOL: begin
        for (int r = 0; r < MaxRules; r++) begin
          if (rule_ok[r] && rule_sym[r] == it.word_byte && (cur & state_mask(rule_src[r])) != 0)
            nxt |= state_mask(rule_dst[r]);
        end
        active_q    = nxt;
        word_open_q = 1'b1;
      end
      KIND_END: begin
        for (int r = 0; r < MaxRules; r++) begin
          if (rule_ok[r] && rule_sym[r] == FinalMark && (cur & state_mask(rule_src[r])) != 0)
            hit = 1'b1;
        end
        expected_verdicts.push_back(hit);
        active_q    = '0;
        word_open_q = 1'b0;
        words_ended++;
      end
      default: ;
    endcase
  endfunction

  // Every field but the kind is random; callers such as load_item and symbol_item set the ones that matter.
  function automatic nfa_item_t random_item(input logic [KindW-1:0] kind);
    nfa_item_t it;
    it.kind      = kind;
    it.index     = IndexW'($urandom);
    it.from      = StateW'($urandom);
    it.symbol    = SymW'($urandom);
    it.to        = StateW'($urandom);
    it.word_byte = SymW'($urandom);
    return it;
  endfunction

  function automatic nfa_item_t load_item(input logic [IndexW-1:0] idx,
                                          input logic [StateW-1:0] from,
                                          input logic [SymW-1:0]   sym,
                                          input logic [StateW-1:0] to);
    nfa_item_t it;
    it        = random_item(KIND_LOAD);
    it.index  = idx;
    it.from   = from;
    it.symbol = sym;
    it.to     = to;
    return it;
  endfunction

  function automatic nfa_item_t symbol_item(input logic [SymW-1:0] b);
    nfa_item_t it;
    it           = random_item(KIND_SYMBOL);
    it.word_byte = b;
    return it;
  endfunction

  task automatic send_item(input nfa_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    // Valid stays high when the next item follows at once.
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= it.kind;
    rule_index_i  <= it.index;
    rule_from_i   <= it.from;
    rule_symbol_i <= it.symbol;
    rule_to_i     <= it.to;
    word_byte_i   <= it.word_byte;
    do @(posedge clk_i); while (in_stall_o);
    predict_nfa_step(it);
    if (it.kind != KindUnused) items_sent++;
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_start_state(input logic [StateW-1:0] value);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    start_q = value;
    start_writes++;
  endtask

  task automatic test_empty_word();
    send_item(random_item(KIND_END));
    send_item(load_item(5'd0, 4'd0, FinalMark, 4'd0));
    send_item(random_item(KIND_END));
  endtask

  task automatic test_directed_words();
    send_item(load_item(5'd31, 4'd0, SymA, 4'd15));
    send_item(load_item(5'd1, 4'd15, 8'd255, 4'd15));
    send_item(load_item(5'd2, 4'd15, 8'd0, 4'd7));
    send_item(load_item(5'd3, 4'd7, FinalMark, 4'd9));
    send_item(symbol_item(SymA));
    send_item(symbol_item(8'd255));
    send_item(random_item(KindUnused));
    send_item(symbol_item(8'd0));
    send_item(random_item(KIND_END));
    // The final marker is also an ordinary transition on that byte.
    send_item(symbol_item(FinalMark));
    send_item(random_item(KIND_END));
    // Byte zero from the start state matches nothing here.
    send_item(symbol_item(8'd0));
    send_item(random_item(KIND_END));
    // A rule loaded mid-word applies to the very next symbol.
    send_item(symbol_item(SymA));
    send_item(load_item(5'd4, 4'd15, SymA, 4'd7));
    send_item(symbol_item(SymA));
    send_item(random_item(KIND_END));
  endtask

  task automatic test_start_register();
    send_item(load_item(5'd5, 4'd15, FinalMark, 4'd0));
    write_start_state(4'd15);
    send_item(random_item(KIND_END));
    send_item(symbol_item(8'd255));
    // The start state is only read when a word begins, so this write must not
    // disturb the open word.
    write_start_state(4'd0);
    send_item(symbol_item(8'd0));
    send_item(random_item(KIND_END));
    send_item(random_item(KIND_END));
  endtask

  task automatic test_backpressure();
    drain_block();
    tx_gap_max     = 0;
    rx_hold_cycles = LongHold;
    for (int n = 0; n < 24; n++) begin
      if (n % 3 == 1) send_item(symbol_item(SymA));
      else send_item(random_item(KIND_END));
    end
    drain_block();
    tx_gap_max = 19;
  endtask

  task automatic test_random_words();
    logic [SymW-1:0]   alphabet [3];
    logic [StateW-1:0] pool [4];
    int unsigned       first_count;
    int unsigned       word_len;
    nfa_item_t         it;
    first_count = items_sent;
    while (items_sent - first_count < ItemTarget) begin
      tx_gap_max   = $urandom_range(0, 1) ? 19 : 0;
      rx_stall_max = $urandom_range(0, 1) ? 19 : 0;
      if ($urandom_range(0, 2) == 0) write_start_state(StateW'($urandom));
      foreach (alphabet[a]) alphabet[a] = SymW'($urandom);
      if ($urandom_range(0, 3) == 0) alphabet[2] = FinalMark;
      // A small pool of states around the start state keeps the words alive.
      pool[0] = start_q;
      for (int p = 1; p < 4; p++) pool[p] = StateW'($urandom);
      repeat ($urandom_range(4, 32)) begin
        it = load_item(IndexW'($urandom), pool[$urandom_range(0, 3)],
                       alphabet[$urandom_range(0, 2)], pool[$urandom_range(0, 3)]);
        if ($urandom_range(0, 3) == 0) it.symbol = FinalMark;
        if ($urandom_range(0, 7) == 0) begin
          it.from = StateW'($urandom);
          it.to   = StateW'($urandom);
        end
        send_item(it);
      end
      repeat ($urandom_range(6, 12)) begin
        word_len = $urandom_range(0, 8);
        for (int k = 0; k < word_len; k++) begin
          if ($urandom_range(0, 19) == 0) send_item(random_item(KindUnused));
          if ($urandom_range(0, 29) == 0)
            send_item(load_item(IndexW'($urandom), pool[$urandom_range(0, 3)],
                                alphabet[$urandom_range(0, 2)], pool[$urandom_range(0, 3)]));
          if ($urandom_range(0, 9) == 0) send_item(random_item(KIND_SYMBOL));
          else send_item(symbol_item(alphabet[$urandom_range(0, 2)]));
        end
        send_item(random_item(KIND_END));
      end
    end
    rx_stall_max = 19;
  endtask

  // Result checker: compares each accepted verdict with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: accepted_o=%0b with no word pending", accepted_o);
        fail_count++;
      end else begin
        if (accepted_o !== expected_verdicts[0]) begin
          $error("accepted mismatch: expected %0b, actual %0b", expected_verdicts[0],
                 accepted_o);
          fail_count++;
        end
        if (accepted_o === 1'b1) words_accepted++;
        verdicts_seen++;
        void'(expected_verdicts.pop_front());
      end
    end
  end

  // Receiver: a random stall before each result, or a long hold when asked.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_cycles != 0) begin
        hold           = rx_hold_cycles;
        rx_hold_cycles = 0;
        long_holds++;
      end else begin
        hold = $urandom_range(0, rx_stall_max);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    start_q     = '0;
    active_q    = '0;
    word_open_q = 1'b0;
    for (int r = 0; r < MaxRules; r++) begin
      rule_ok[r]  = 1'b0;
      rule_src[r] = '0;
      rule_sym[r] = '0;
      rule_dst[r] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_word();
    test_directed_words();
    test_start_register();
    test_backpressure();
    test_random_words();

    in_valid_i <= 1'b0;
    for (int c = 0; c < FinalWait && expected_verdicts.size() != 0; c++) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", expected_verdicts.size());
      fail_count += expected_verdicts.size();
    end

    $display("Sent %0d items over %0d start-state settings; %0d long receiver holds.",
             items_sent, start_writes, long_holds);
    $display("Checked %0d of %0d word verdicts, %0d of them accepting.", verdicts_seen,
             words_ended, words_accepted);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitTime);
    $display("Timeout: the run did not complete in time.");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
